/* rtl/core/mos_pkg.sv */
// ----------------------------------------------------------------------------
// mos_pkg
// Shared types and constants for the median-of-samples core.
// ----------------------------------------------------------------------------
package mos_pkg;

  localparam int unsigned SampleW = 32;
  localparam int unsigned MedianW = SampleW + 1;
  localparam int unsigned CountW  = 5;

  // Control broadcast to every cell of the sorted row
  typedef struct packed {
    logic               insert;  // place sample, shift larger entries up
    logic               drain;   // each cell takes its upper neighbor; the top cell keeps its value
    logic [SampleW-1:0] sample;
  } cell_ctrl_t;

endpackage

/* rtl/core/mos_in_if.sv */
// ----------------------------------------------------------------------------
// mos_in_if
// Sample stream: valid/ready handshake carrying one sample and its last flag.
// ----------------------------------------------------------------------------
interface mos_in_if;
  import mos_pkg::*;

  logic               valid;
  logic               ready;
  logic [SampleW-1:0] sample;
  logic               last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);

endinterface

/* rtl/core/mos_out_if.sv */
// ----------------------------------------------------------------------------
// mos_out_if
// Result stream: valid/ready handshake carrying the doubled median of a set.
// ----------------------------------------------------------------------------
interface mos_out_if;
  import mos_pkg::*;

  logic               valid;
  logic               ready;
  logic [MedianW-1:0] median_doubled;
  logic [CountW-1:0]  sample_count;
  logic               overflow;

  modport source (output valid, output median_doubled, output sample_count,
                  output overflow, input ready);
  modport sink   (input valid, input median_doubled, input sample_count,
                  input overflow, output ready);

endinterface

/* rtl/core/median_of_samples_core.sv */
// ----------------------------------------------------------------------------
// median_of_samples_core
// Streaming median of a set of unsigned samples, kept sorted in a cell row.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one 32-bit sample per transfer; last marks the end of a set.
//   Each sample is inserted into a row of MAX_SAMPLES cells kept in ascending
//   order, one sample per cycle. Samples beyond MAX_SAMPLES are dropped and
//   the overflow flag of that set is raised.
//   On a transfer with last set, the row is shifted down toward cell 0 and the
//   middle entries are picked off as they pass, until entry n/2 of a set of n
//   kept samples reaches cell 0; then the output register is loaded. in_i is not
//   ready during that time; all other samples are taken at one per cycle.
//   out_o presents median_doubled (sum of the two middle samples, or twice
//   the middle one), sample_count and overflow.
//   If out is stalled, the result waits in the output register; new samples
//   are still taken, and the next set end waits until the register is free.
//   Reset empties the row and the output register; no clearing pass runs.
// ----------------------------------------------------------------------------
module median_of_samples_core #(
  parameter int unsigned MAX_SAMPLES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  mos_in_if.sink           in_i,
  mos_out_if.source        out_o
);
  import mos_pkg::*;

  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DRAIN = 2'd1;
  localparam logic [1:0] ST_HOLD  = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [CW-1:0]      fill_q, fill_d;
  logic               drop_q, drop_d;
  logic [CW-1:0]      cnt_q, cnt_d;      // kept count of the set being drained
  logic               ovf_q, ovf_d;
  logic [CW-1:0]      k_q, k_d;          // index of the entry now in cell 0
  logic [SampleW-1:0] lo_q, lo_d, hi_q, hi_d;

  logic               out_valid_q, out_valid_d;
  logic [MedianW-1:0] out_med_q, out_med_d;
  logic [CountW-1:0]  out_cnt_q, out_cnt_d;
  logic               out_ovf_q, out_ovf_d;

  logic               in_fire, room, out_load;
  logic [CW-1:0]      mid, lo_idx;
  cell_ctrl_t         ctrl;

  logic [SampleW-1:0] cell_val  [MAX_SAMPLES];
  logic               cell_open [MAX_SAMPLES];
  logic               cell_vld  [MAX_SAMPLES];

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign room       = (fill_q < CW'(MAX_SAMPLES));

  assign mid    = cnt_q >> 1;
  assign lo_idx = cnt_q[0] ? mid : mid - CW'(1);

  assign ctrl.insert = in_fire && room;
  assign ctrl.drain  = (state_q == ST_DRAIN);
  assign ctrl.sample = in_i.sample;

  // Sorted row
  for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
    assign cell_vld[i] = (CW'(i) < fill_q);

    if (i == 0) begin : g_first
      mos_cell u_cell (
        .clk_i      (clk_i),
        .ctrl_i     (ctrl),
        .valid_i    (cell_vld[i]),
        .prev_open_i(1'b0),
        .prev_val_i (ctrl.sample),
        .next_val_i (cell_val[i+1]),
        .open_o     (cell_open[i]),
        .val_o      (cell_val[i])
      );
    end else if (i == MAX_SAMPLES - 1) begin : g_last
      mos_cell u_cell (
        .clk_i      (clk_i),
        .ctrl_i     (ctrl),
        .valid_i    (cell_vld[i]),
        .prev_open_i(cell_open[i-1]),
        .prev_val_i (cell_val[i-1]),
        .next_val_i (cell_val[i]),
        .open_o     (cell_open[i]),
        .val_o      (cell_val[i])
      );
    end else begin : g_mid
      mos_cell u_cell (
        .clk_i      (clk_i),
        .ctrl_i     (ctrl),
        .valid_i    (cell_vld[i]),
        .prev_open_i(cell_open[i-1]),
        .prev_val_i (cell_val[i-1]),
        .next_val_i (cell_val[i+1]),
        .open_o     (cell_open[i]),
        .val_o      (cell_val[i])
      );
    end
  end

  assign out_load = (state_q == ST_HOLD) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    drop_d      = drop_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    k_d         = k_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    out_valid_d = out_valid_q;
    out_med_d   = out_med_q;
    out_cnt_d   = out_cnt_q;
    out_ovf_d   = out_ovf_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_i.last) begin
            cnt_d   = room ? fill_q + CW'(1) : fill_q;
            ovf_d   = drop_q || !room;
            fill_d  = '0;
            drop_d  = 1'b0;
            k_d     = '0;
            state_d = ST_DRAIN;
          end else if (room) begin
            fill_d = fill_q + CW'(1);
          end else begin
            drop_d = 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        if (k_q == lo_idx) begin
          lo_d = cell_val[0];
        end
        if (k_q == mid) begin
          hi_d    = cell_val[0];
          state_d = ST_HOLD;
        end
        k_d = k_q + CW'(1);
      end
      ST_HOLD: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          out_med_d   = {1'b0, lo_q} + {1'b0, hi_q};
          out_cnt_d   = CountW'(cnt_q);
          out_ovf_d   = ovf_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q     <= cnt_d;
    ovf_q     <= ovf_d;
    k_q       <= k_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    out_med_q <= out_med_d;
    out_cnt_q <= out_cnt_d;
    out_ovf_q <= out_ovf_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.median_doubled = out_med_q;
  assign out_o.sample_count   = out_cnt_q;
  assign out_o.overflow       = out_ovf_q;

`ifndef SYNTHESIS
  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(MAX_SAMPLES))
    else $error("fill count beyond row depth");

  a_set_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.last) |=> (state_q == ST_DRAIN) && (fill_q == '0) && !drop_q)
    else $error("set end did not start drain with an empty row");

  a_drain_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> (k_q <= mid))
    else $error("drain ran past the middle entry");

  a_sorted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_IDLE) && (fill_q >= CW'(2))) |-> (cell_val[0] <= cell_val[1]))
    else $error("row out of order");
`endif

endmodule

/* rtl/core/mos_cell.sv */
// ----------------------------------------------------------------------------
// mos_cell
// One entry of the sorted row. On insert it either keeps its value, takes the
// new sample, or takes the value of its lower neighbor; on drain it takes the
// value of its upper neighbor.
// ----------------------------------------------------------------------------
module mos_cell (
  input  logic                        clk_i,
  input  mos_pkg::cell_ctrl_t         ctrl_i,
  input  logic                        valid_i,     // entry holds a kept sample
  input  logic                        prev_open_i, // lower neighbor moves up
  input  logic [mos_pkg::SampleW-1:0] prev_val_i,
  input  logic [mos_pkg::SampleW-1:0] next_val_i,
  output logic                        open_o,      // this entry moves up
  output logic [mos_pkg::SampleW-1:0] val_o
);
  import mos_pkg::*;

  logic [SampleW-1:0] val_q, val_d;

  // Empty, or strictly larger than the new sample: equal values stay below it
  assign open_o = !valid_i || (val_q > ctrl_i.sample);

  always_comb begin
    val_d = val_q;
    if (ctrl_i.insert) begin
      if (prev_open_i) begin
        val_d = prev_val_i;
      end else if (open_o) begin
        val_d = ctrl_i.sample;
      end
    end else if (ctrl_i.drain) begin
      val_d = next_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

/* tb/median_of_samples_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_of_samples_core_tb
// Self-checking bench for the streaming median core. Sets of samples go in
// over the sample stream with random gaps. A local sorted-row predictor works
// out the doubled median, the kept count and the overflow flag of each set.
// Every result transfer is compared in order against the queued predictions,
// while the result side stalls at random.
// ----------------------------------------------------------------------------
module median_of_samples_core_tb;
  import mos_pkg::*;

  localparam int unsigned MAX_SAMPLES      = 16;
  localparam int unsigned RANDOM_ITEM_GOAL = 1000;
  localparam int unsigned STEADY_ITEMS     = 150;
  localparam int unsigned DRAIN_CYCLES     = 4 * (MAX_SAMPLES / 2 + 2);
  localparam int unsigned CYCLE_LIMIT      = 200000;
  localparam int unsigned MAX_REPORTS      = 10;

  typedef struct packed {
    logic [MedianW-1:0] median_doubled;
    logic [CountW-1:0]  sample_count;
    logic               overflow;
  } median_result_t;

  typedef enum int unsigned {MIX_FULL, MIX_LOW, MIX_HIGH, MIX_EXTREME} sample_mix_e;

  logic clk_i;
  logic rst_ni;

  mos_in_if  in_if ();
  mos_out_if out_if ();

  median_of_samples_core #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  // Predictor state: kept samples in ascending order
  logic [SampleW-1:0] kept_sorted [MAX_SAMPLES];
  int unsigned        kept_count;
  bit                 kept_dropped;

  median_result_t     expected_medians[$];
  int unsigned        error_count;
  int unsigned        items_sent;
  int unsigned        cycle_count;
  bit                 idle_en;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic void predict_sample(input logic [SampleW-1:0] value, input logic is_last);
    int unsigned    pos;
    median_result_t res;
    if (kept_count < MAX_SAMPLES) begin
      pos = kept_count;
      while (pos > 0 && kept_sorted[pos-1] > value) begin
        kept_sorted[pos] = kept_sorted[pos-1];
        pos--;
      end
      kept_sorted[pos] = value;
      kept_count++;
    end else begin
      kept_dropped = 1'b1;
    end
    if (is_last) begin
      if (kept_count % 2 == 1) begin
        res.median_doubled = {kept_sorted[kept_count/2], 1'b0};
      end else begin
        res.median_doubled = {1'b0, kept_sorted[kept_count/2-1]} +
                             {1'b0, kept_sorted[kept_count/2]};
      end
      res.sample_count = kept_count[CountW-1:0];
      res.overflow     = kept_dropped;
      expected_medians.push_back(res);
      kept_count   = 0;
      kept_dropped = 1'b0;
    end
  endfunction

  // Called at a rising edge; returns at the edge of the transfer
  task automatic send_sample(input logic [SampleW-1:0] value, input logic is_last);
    int unsigned gap;
    bit          taken;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.sample <= value;
    in_if.last   <= is_last;
    do begin
      @(negedge clk_i);
      taken = in_if.ready;
      @(posedge clk_i);
    end while (!taken);
    items_sent++;
    predict_sample(value, is_last);
  endtask

  function automatic logic [SampleW-1:0] pick_sample(input sample_mix_e mix);
    case (mix)
      MIX_LOW:     return SampleW'($urandom_range(0, 15));
      MIX_HIGH:    return 32'hFFFF_FFFF - SampleW'($urandom_range(0, 15));
      MIX_EXTREME: return $urandom_range(0, 1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
      default:     return $urandom();
    endcase
  endfunction

  task automatic send_random_set(input int unsigned len);
    sample_mix_e mix;
    mix = $urandom_range(0, 1) ? MIX_FULL : sample_mix_e'($urandom_range(0, 3));
    for (int unsigned i = 1; i <= len; i++) begin
      send_sample(pick_sample(mix), i == len);
    end
  endtask

  task automatic test_directed_sets();
    send_sample(32'h0000_0000, 1'b1);
    send_sample(32'hFFFF_FFFF, 1'b1);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b1);
    // equal values around the middle
    send_sample(32'd9, 1'b0);
    send_sample(32'd7, 1'b0);
    send_sample(32'd2, 1'b0);
    send_sample(32'd7, 1'b1);
    // fill the row descending, then the last sample is dropped
    for (int unsigned i = 0; i < MAX_SAMPLES; i++) begin
      send_sample(32'h8000_0000 - i * 32'h0101_0101, 1'b0);
    end
    send_sample(32'h0000_0000, 1'b1);
  endtask

  task automatic test_drain_pause();
    send_random_set(5);
    in_if.valid <= 1'b0;
    while (expected_medians.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_random_sets();
    int unsigned len;
    while (items_sent < RANDOM_ITEM_GOAL) begin
      if ($urandom_range(0, 9) == 0) begin
        len = $urandom_range(MAX_SAMPLES + 1, MAX_SAMPLES + 6);
      end else begin
        len = $urandom_range(1, MAX_SAMPLES);
      end
      send_random_set(len);
    end
  endtask

  task automatic test_back_to_back_sets();
    int unsigned start;
    idle_en = 1'b0;
    start   = items_sent;
    while (items_sent - start < STEADY_ITEMS) begin
      send_random_set($urandom_range(0, 2) == 0 ? 1 : $urandom_range(1, MAX_SAMPLES + 2));
    end
  endtask

  // Result side: random stall bursts, in-order compare on each transfer
  initial begin : result_checker
    int unsigned    stall_left;
    median_result_t got;
    median_result_t want;
    out_if.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        got = '{out_if.median_doubled, out_if.sample_count, out_if.overflow};
        if (expected_medians.size() == 0) begin
          if (error_count < MAX_REPORTS) begin
            $display("ERROR: unexpected result median=%0d count=%0d ovf=%0b",
                     got.median_doubled, got.sample_count, got.overflow);
          end
          error_count++;
        end else begin
          want = expected_medians.pop_front();
          if (got !== want) begin
            if (error_count < MAX_REPORTS) begin
              $display("ERROR: median exp %0d got %0d, count exp %0d got %0d, ovf exp %0b got %0b",
                       want.median_doubled, got.median_doubled, want.sample_count,
                       got.sample_count, want.overflow, got.overflow);
            end
            error_count++;
          end
        end
      end
      @(posedge clk_i);
      if (stall_left == 0 && idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 4);
      end
      out_if.ready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.sample = '0;
    in_if.last   = 1'b0;
    kept_count   = 0;
    kept_dropped = 1'b0;
    error_count  = 0;
    items_sent   = 0;
    idle_en      = 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_sets();
    test_drain_pause();
    test_random_sets();
    test_back_to_back_sets();

    in_if.valid <= 1'b0;
    while (expected_medians.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
